[rtl/core/hmq_pkg.sv]
// ----------------------------------------------------------------------------
// hmq_pkg: shared types and constants of the binary max-heap queue
// Item layouts, stored entry layout, status and operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmq_pkg;

  // Field widths of the item channels
  localparam int KEY_WIDTH      = 32;
  localparam int VALUE_WIDTH    = 32;
  localparam int STATUS_WIDTH   = 2;
  localparam int COUNT_WIDTH    = 7;

  // Default number of heap entries
  localparam int CAPACITY_DEF   = 64;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_WIDTH-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_MISS = 2'd2;

  // Input item
  typedef struct packed {
    logic                   op;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } hmq_in_t;

  // Result item
  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic [KEY_WIDTH-1:0]    found_key;
    logic [VALUE_WIDTH-1:0]  found_value;
    logic [COUNT_WIDTH-1:0]  entry_count;
  } hmq_out_t;

  // One stored heap entry
  typedef struct packed {
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } hmq_entry_t;

  // Outcome of the shared key compare
  typedef struct packed {
    logic lt;
    logic eq;
  } hmq_cmp_t;

endpackage

`default_nettype wire

[rtl/core/hmq_ram.sv]
// ----------------------------------------------------------------------------
// hmq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/hmq_cmp.sv]
// ----------------------------------------------------------------------------
// hmq_cmp: shared key comparator
// Less-than in unsigned or two's complement order, and bitwise equality.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmq_cmp (
  input  wire logic [hmq_pkg::KEY_WIDTH-1:0] a_i,
  input  wire logic [hmq_pkg::KEY_WIDTH-1:0] b_i,
  input  wire logic                          signed_i,
  output hmq_pkg::hmq_cmp_t                  res_o
);

  import hmq_pkg::*;

  logic [KEY_WIDTH-1:0] a_ord;
  logic [KEY_WIDTH-1:0] b_ord;

  // Flip the sign bit so one unsigned compare serves both orders
  always_comb begin
    a_ord = a_i;
    b_ord = b_i;
    a_ord[KEY_WIDTH-1] = a_i[KEY_WIDTH-1] ^ signed_i;
    b_ord[KEY_WIDTH-1] = b_i[KEY_WIDTH-1] ^ signed_i;
  end

  assign res_o.lt = a_ord < b_ord;
  assign res_o.eq = a_i == b_i;

endmodule

`default_nettype wire

[rtl/core/binary_max_heap_queue.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_queue: key/value priority queue kept as a binary max-heap
// Sequencer, working registers and result register around one entry RAM.
// ----------------------------------------------------------------------------
// One item is worked on at a time; in_stall_o is high from acceptance until
// the result is loaded into the output register. All heap reads go through
// the single read port of the entry RAM. An insert into a full heap is
// refused with a full status; any other insert sifts the new entry up. A
// remove scans for the key, reading one entry per cycle, and reports a miss
// when the key is absent; else it moves the last entry into the hole, sifts
// it down and, if it did not move, sifts it up. The entry RAM needs no
// clearing after reset: only entries below the count are ever read. Results
// wait in an output register until taken.
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue #(
  parameter int CAPACITY = hmq_pkg::CAPACITY_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hmq_pkg::hmq_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hmq_pkg::hmq_out_t      out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i
);

  import hmq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 2;
  localparam int ENT_W = KEY_WIDTH + VALUE_WIDTH;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_LAST     = 4'd2;
  localparam logic [3:0] S_SD_START = 4'd3;
  localparam logic [3:0] S_SD_L     = 4'd4;
  localparam logic [3:0] S_SD_R     = 4'd5;
  localparam logic [3:0] S_SD_DEC   = 4'd6;
  localparam logic [3:0] S_SU_RD    = 4'd7;
  localparam logic [3:0] S_SU_CMP   = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    signed_q;
  hmq_entry_t              hold_q, hold_d;
  hmq_entry_t              child_q, child_d;
  logic [IDX_W-1:0]        child_idx_q, child_idx_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [IDX_W-1:0]        hit_q, hit_d;
  logic [CNT_W-1:0]        scan_q, scan_d;
  logic                    chk_v_q, chk_v_d;
  logic [IDX_W-1:0]        chk_idx_q, chk_idx_d;
  logic [STATUS_WIDTH-1:0] res_status_q, res_status_d;
  logic [KEY_WIDTH-1:0]    res_key_q, res_key_d;
  logic [VALUE_WIDTH-1:0]  res_val_q, res_val_d;
  logic                    out_valid_q;
  hmq_out_t                out_q;

  // RAM and compare unit hookup
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  hmq_entry_t              ram_wdata, ram_rdata;
  logic [ENT_W-1:0]        ram_rdata_raw;
  logic                    cmp_a_child, cmp_b_child;
  logic [KEY_WIDTH-1:0]    cmp_a, cmp_b;
  hmq_cmp_t                cmp_res;

  logic [CH_W-1:0]         ch_w, ch_r, count_ext;
  logic [IDX_W-1:0]        parent;
  logic [CNT_W-1:0]        last_idx;
  logic                    accept;

  hmq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = hmq_entry_t'(ram_rdata_raw);

  assign cmp_a = cmp_a_child ? child_q.key : hold_q.key;
  assign cmp_b = cmp_b_child ? child_q.key : ram_rdata.key;

  hmq_cmp u_cmp (
    .a_i      (cmp_a),
    .b_i      (cmp_b),
    .signed_i (signed_q),
    .res_o    (cmp_res)
  );

  // Index arithmetic of the heap
  assign ch_w      = {1'b0, pos_q, 1'b1};
  assign ch_r      = CH_W'({1'b0, child_idx_q}) + CH_W'(1);
  assign count_ext = CH_W'(count_q);
  assign parent    = IDX_W'((pos_q - IDX_W'(1)) >> 1);
  assign last_idx  = count_q - CNT_W'(1);

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    hold_d       = hold_q;
    child_d      = child_q;
    child_idx_d  = child_idx_q;
    pos_d        = pos_q;
    hit_d        = hit_q;
    scan_d       = scan_q;
    chk_v_d      = chk_v_q;
    chk_idx_d    = chk_idx_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    ram_we       = 1'b0;
    ram_waddr    = pos_q;
    ram_wdata    = hold_q;
    ram_re       = 1'b0;
    ram_raddr    = pos_q;
    cmp_a_child  = 1'b0;
    cmp_b_child  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          hold_d.key   = in_data_i.key;
          hold_d.value = in_data_i.value;
          res_status_d = ST_OK;
          res_key_d    = '0;
          res_val_d    = '0;
          scan_d       = '0;
          chk_v_d      = 1'b0;
          if (in_data_i.op == OP_INSERT) begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else begin
              pos_d   = IDX_W'(count_q);
              count_d = count_q + CNT_W'(1);
              state_d = S_SU_RD;
            end
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      // Read one entry per cycle, check the one read the cycle before
      S_SCAN: begin
        if (chk_v_q && cmp_res.eq) begin
          res_key_d = ram_rdata.key;
          res_val_d = ram_rdata.value;
          hit_d     = chk_idx_q;
          count_d   = last_idx;
          if (CNT_W'(chk_idx_q) == last_idx) begin
            state_d = S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(last_idx);
            state_d   = S_LAST;
          end
        end else if (scan_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(scan_q);
          chk_v_d   = 1'b1;
          chk_idx_d = IDX_W'(scan_q);
          scan_d    = scan_q + CNT_W'(1);
        end else if (!chk_v_q) begin
          res_status_d = ST_MISS;
          state_d      = S_DONE;
        end else begin
          chk_v_d = 1'b0;
        end
      end

      // Take the last entry into the hole
      S_LAST: begin
        hold_d  = ram_rdata;
        pos_d   = hit_q;
        state_d = S_SD_START;
      end

      S_SD_START: begin
        if (ch_w >= count_ext) begin
          if (pos_q == hit_q) begin
            state_d = S_SU_RD;
          end else begin
            ram_we  = 1'b1;
            state_d = S_DONE;
          end
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = IDX_W'(ch_w);
          child_idx_d = IDX_W'(ch_w);
          state_d     = S_SD_L;
        end
      end

      S_SD_L: begin
        child_d = ram_rdata;
        if (ch_r < count_ext) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(ch_r);
          state_d   = S_SD_R;
        end else begin
          state_d = S_SD_DEC;
        end
      end

      // Pick the larger child, left on a tie
      S_SD_R: begin
        cmp_a_child = 1'b1;
        if (cmp_res.lt) begin
          child_d     = ram_rdata;
          child_idx_d = IDX_W'(ch_r);
        end
        state_d = S_SD_DEC;
      end

      // Stop at a child not larger than the moving entry, else move it up
      S_SD_DEC: begin
        cmp_b_child = 1'b1;
        if (!cmp_res.lt) begin
          if (pos_q == hit_q) begin
            state_d = S_SU_RD;
          end else begin
            ram_we  = 1'b1;
            state_d = S_DONE;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = child_q;
          pos_d     = child_idx_q;
          state_d   = S_SD_START;
        end
      end

      S_SU_RD: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = parent;
          state_d   = S_SU_CMP;
        end
      end

      // Stop under a strictly larger parent, else pull the parent down
      S_SU_CMP: begin
        if (cmp_res.lt) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_d     = parent;
          state_d   = S_SU_RD;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      signed_q <= 1'b0;
      chk_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      chk_v_q <= chk_v_d;
      if (cfg_we_i) begin
        signed_q <= cfg_wdata_i;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    hold_q       <= hold_d;
    child_q      <= child_d;
    child_idx_q  <= child_idx_d;
    pos_q        <= pos_d;
    hit_q        <= hit_d;
    scan_q       <= scan_d;
    chk_idx_q    <= chk_idx_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
  end

  // Output register: load a finished item, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_q.status      <= res_status_q;
      out_q.found_key   <= res_key_q;
      out_q.found_value <= res_val_q;
      out_q.entry_count <= COUNT_WIDTH'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
